// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, status codes and character tables for the front, queue and
// back of the string decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam logic [1:0] ST_DATA   = 2'd0;
   localparam logic [1:0] ST_CLOSED = 2'd1;
   localparam logic [1:0] ST_UNTERM = 2'd2;
   localparam logic [1:0] ST_NOOPEN = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF_CONT  = 8'h80;
   localparam logic [5:0]  UTF_MASK  = 6'h3F;
   localparam logic [15:0] UTF_LIM1  = 16'h0080;
   localparam logic [15:0] UTF_LIM2  = 16'h0800;

   // Result bytes caused by one text byte, status shared by all of them.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] status;
   } jsu_group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_qstat_type;

   function automatic logic [3:0] hex_value(input logic [7:0] h);
      logic [3:0] v;
      v = 4'd0;
      if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
      else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
      else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
      return v;
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape front
// Accepts text bytes, tracks string/escape/hex mode and turns each byte
// into a group of zero to three result bytes for the queue.
// ----------------------------------------------------------------------------
module jsu_front
   import jsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    text_byte,
   output logic          push,
   output jsu_group_type group
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   mode_type    mode_ff,  mode_in;
   logic [1:0]  hex_ff,   hex_in;
   logic [15:0] cp_ff,    cp_in;
   logic [15:0] cp_next;

   assign cp_next = {cp_ff[11:0], hex_value(text_byte)};

   always_comb begin
      mode_in      = mode_ff;
      hex_in       = hex_ff;
      cp_in        = cp_ff;
      group.count  = 2'd0;
      group.b0     = 8'h00;
      group.b1     = 8'h00;
      group.b2     = 8'h00;
      group.status = ST_DATA;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (text_byte == CH_QUOTE) begin
               mode_in = MODE_STR;
            end else begin
               group.count  = 2'd1;
               group.status = ST_NOOPEN;
            end
         end
         MODE_STR: begin
            if (text_byte == CH_NUL) begin
               group.count  = 2'd1;
               group.status = ST_UNTERM;
               mode_in      = MODE_IDLE;
            end else if (text_byte == CH_QUOTE) begin
               group.count  = 2'd1;
               group.status = ST_CLOSED;
               mode_in      = MODE_IDLE;
            end else if (text_byte == CH_BSL) begin
               mode_in = MODE_ESC;
            end else begin
               group.count = 2'd1;
               group.b0    = text_byte;
            end
         end
         MODE_ESC: begin
            if (text_byte == CH_NUL) begin
               group.count  = 2'd1;
               group.status = ST_UNTERM;
               mode_in      = MODE_IDLE;
            end else if (text_byte == CH_U) begin
               hex_in  = 2'd0;
               cp_in   = 16'h0000;
               mode_in = MODE_HEX;
            end else begin
               group.count = 2'd1;
               group.b0    = escape_map(text_byte);
               mode_in     = MODE_STR;
            end
         end
         MODE_HEX: begin
            if (text_byte == CH_NUL) begin
               group.count  = 2'd1;
               group.status = ST_UNTERM;
               hex_in       = 2'd0;
               cp_in        = 16'h0000;
               mode_in      = MODE_IDLE;
            end else begin
               cp_in = cp_next;
               if (hex_ff != 2'd3) begin
                  hex_in = hex_ff + 2'd1;
               end else begin
                  hex_in  = 2'd0;
                  mode_in = MODE_STR;
                  // drop a zero code point
                  if (cp_next == 16'h0000) begin
                     group.count = 2'd0;
                  end else if (cp_next < UTF_LIM1) begin
                     group.count = 2'd1;
                     group.b0    = cp_next[7:0];
                  end else if (cp_next < UTF_LIM2) begin
                     group.count = 2'd2;
                     group.b0    = UTF_LEAD2 | {3'b000, cp_next[10:6]};
                     group.b1    = UTF_CONT | {2'b00, cp_next[5:0] & UTF_MASK};
                  end else begin
                     group.count = 2'd3;
                     group.b0    = UTF_LEAD3 | {4'h0, cp_next[15:12]};
                     group.b1    = UTF_CONT | {2'b00, cp_next[11:6] & UTF_MASK};
                     group.b2    = UTF_CONT | {2'b00, cp_next[5:0] & UTF_MASK};
                  end
               end
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   assign push = accept && (group.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hex_ff  <= 2'd0;
         cp_ff   <= 16'h0000;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
         cp_ff   <= cp_in;
      end
   end

endmodule

// ===== rtl/jsu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape queue
// Short register queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int Depth = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  jsu_group_type wr_group,
   input  logic          pop,
   output jsu_group_type rd_group,
   output jsu_qstat_type qstat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   jsu_group_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign qstat.full  = (count_ff == CntW'(Depth));
   assign qstat.empty = (count_ff == '0);
   assign rd_group    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape back
// Pulls groups from the queue and sends their bytes out one item per cycle
// while rsp_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back
   import jsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  jsu_group_type head,
   input  jsu_qstat_type qstat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic [1:0]    rsp_status,
   output logic          rsp_run_last
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic [1:0] status_ff;
   logic       last_ff;
   logic [1:0] rem_ff;
   logic [7:0] next1_ff;
   logic [7:0] next2_ff;
   logic       load;

   assign load = !valid_ff || !rsp_stall;
   assign pop  = load && (rem_ff == 2'd0) && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= 2'd0;
      end else if (load) begin
         if (rem_ff != 2'd0) begin
            // continue the current multi-byte group
            valid_ff <= 1'b1;
            byte_ff  <= next1_ff;
            last_ff  <= (rem_ff == 2'd1);
            next1_ff <= next2_ff;
            rem_ff   <= rem_ff - 2'd1;
         end else if (!qstat.empty) begin
            valid_ff  <= 1'b1;
            byte_ff   <= head.b0;
            status_ff <= head.status;
            last_ff   <= (head.count == 2'd1);
            next1_ff  <= head.b1;
            next2_ff  <= head.b2;
            rem_ff    <= head.count - 2'd1;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_run_last = last_ff;

endmodule

// ===== rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape
// Streaming JSON string decoder: one text byte in per item, decoded string
// bytes and string status out, with \uXXXX expanded to UTF-8.
// ----------------------------------------------------------------------------
// Path: a result passes a queue entry register, then the output register.
// Throughput: one text byte per cycle unless req_stall; the output sends one
//   item per cycle unless rsp_stall, so a \u escape's two or three UTF-8 bytes
//   leave in turn; the queue between front and back absorbs the burst.
// Reset: synchronous, active high; clears mode, hex count, code point,
//   queue pointers and the output valid.
module json_string_unescape
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_run_last
);

   logic          accept;
   logic          push;
   logic          pop;
   jsu_group_type wr_group;
   jsu_group_type head;
   jsu_qstat_type qstat;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .push      (push),
      .group     (wr_group)
   );

   jsu_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_group (wr_group),
      .pop      (pop),
      .rd_group (head),
      .qstat    (qstat)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("group pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("group popped from an empty queue");

   a_status_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DATA) |-> (rsp_out_byte == 8'h00 && rsp_run_last))
      else $error("status item carries data or is not last");

   a_push_group: assert property (@(posedge clock) disable iff (reset)
      (push && wr_group.status != ST_DATA) |-> (wr_group.count == 2'd1))
      else $error("status group with more than one item");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Feeds text bytes through the valid/stall input and checks every decoded
// byte and string status against a cycle-free decoder kept in step with the
// accepted input: directed strings first, then long random streams of
// well-formed strings with noise, broken strings and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import jsu_pkg::*;

   localparam int N_DIRECTED   = 28;
   localparam int RANDOM_ITEMS = 160;
   localparam int QUIET_ITEMS  = 60;
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_PCT     = 9;
   localparam int TAIL_CYCLES  = 10;
   localparam int DRAIN_LIMIT  = 5000;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_STRING,
      SCAN_ESCAPE,
      SCAN_HEX
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       run_last;
   } decoded_type;

   // One text byte, with its single result typed in where it is obvious.
   typedef struct packed {
      logic [7:0] text;
      logic       typed;
      logic [7:0] exp_byte;
      logic [1:0] exp_status;
   } stim_row_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_run_last;

   json_string_unescape u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .rsp_run_last  (rsp_run_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CH_NUL,   1'b1, 8'h00, ST_NOOPEN},   // end of text while idle
      '{8'hFF,    1'b1, 8'h00, ST_NOOPEN},
      '{CH_QUOTE, 1'b0, 8'h00, ST_DATA},
      '{8'h01,    1'b1, 8'h01, ST_DATA},
      '{8'hFF,    1'b1, 8'hFF, ST_DATA},
      '{CH_BSL,   1'b0, 8'h00, ST_DATA},
      '{"t",      1'b0, 8'h00, ST_DATA},
      '{CH_BSL,   1'b0, 8'h00, ST_DATA},     // \uFfZ1: Z counts as digit 0
      '{CH_U,     1'b0, 8'h00, ST_DATA},
      '{"F",      1'b0, 8'h00, ST_DATA},
      '{"f",      1'b0, 8'h00, ST_DATA},
      '{"Z",      1'b0, 8'h00, ST_DATA},
      '{"1",      1'b0, 8'h00, ST_DATA},
      '{CH_QUOTE, 1'b1, 8'h00, ST_CLOSED},
      '{CH_QUOTE, 1'b0, 8'h00, ST_DATA},     // \u0000 is dropped
      '{CH_BSL,   1'b0, 8'h00, ST_DATA},
      '{CH_U,     1'b0, 8'h00, ST_DATA},
      '{"0",      1'b0, 8'h00, ST_DATA},
      '{"0",      1'b0, 8'h00, ST_DATA},
      '{"0",      1'b0, 8'h00, ST_DATA},
      '{"0",      1'b0, 8'h00, ST_DATA},
      '{CH_BSL,   1'b0, 8'h00, ST_DATA},
      '{CH_NUL,   1'b1, 8'h00, ST_UNTERM},   // end of text after backslash
      '{CH_QUOTE, 1'b0, 8'h00, ST_DATA},
      '{CH_BSL,   1'b0, 8'h00, ST_DATA},
      '{CH_U,     1'b0, 8'h00, ST_DATA},
      '{"7",      1'b0, 8'h00, ST_DATA},
      '{CH_NUL,   1'b1, 8'h00, ST_UNTERM}    // end of text among hex digits
   };

   logic [7:0] escape_letters [5] = '{"b", "f", "n", "r", "t"};

   // Decoder state, advanced once per accepted text byte.
   scan_mode_type scan_mode    = SCAN_IDLE;
   logic [1:0]    digits_taken = 2'd0;
   logic [15:0]   code_acc     = 16'h0000;

   decoded_type  byte_group [$];
   decoded_type  expected_q [$];
   stim_row_type pending_rows [$];

   int errors         = 0;
   int items_offered  = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int status_count [4] = '{0, 0, 0, 0};

   logic sender_quiet = 1'b0;
   logic rsp_quiet    = 1'b0;
   logic hold_request = 1'b0;
   int   hold_count;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c[3:0];
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return 4'(c[3:0] + 4'd9);
      return 4'd0;
   endfunction

   function automatic logic [7:0] control_code_of(input logic [7:0] c);
      case (c)
         "b":     return 8'h08;
         "f":     return 8'h0C;
         "n":     return 8'h0A;
         "r":     return 8'h0D;
         "t":     return 8'h09;
         default: return c;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   task automatic emit(input logic [7:0] b, input logic [1:0] st);
      decoded_type d;
      d = '{b, st, 1'b0};
      byte_group.push_back(d);
   endtask

   task automatic decode_text(input logic [7:0] b);
      logic [15:0] cp;
      decoded_type tail;
      byte_group.delete();
      case (scan_mode)
         SCAN_IDLE: begin
            if (b == CH_QUOTE) scan_mode = SCAN_STRING;
            else emit(8'h00, ST_NOOPEN);
         end
         SCAN_STRING: begin
            if (b == CH_NUL) begin
               emit(8'h00, ST_UNTERM);
               scan_mode = SCAN_IDLE;
            end else if (b == CH_QUOTE) begin
               emit(8'h00, ST_CLOSED);
               scan_mode = SCAN_IDLE;
            end else if (b == CH_BSL) begin
               scan_mode = SCAN_ESCAPE;
            end else begin
               emit(b, ST_DATA);
            end
         end
         SCAN_ESCAPE: begin
            if (b == CH_NUL) begin
               emit(8'h00, ST_UNTERM);
               scan_mode = SCAN_IDLE;
            end else if (b == CH_U) begin
               digits_taken = 2'd0;
               code_acc     = 16'h0000;
               scan_mode    = SCAN_HEX;
            end else begin
               emit(control_code_of(b), ST_DATA);
               scan_mode = SCAN_STRING;
            end
         end
         default: begin
            if (b == CH_NUL) begin
               emit(8'h00, ST_UNTERM);
               digits_taken = 2'd0;
               code_acc     = 16'h0000;
               scan_mode    = SCAN_IDLE;
            end else begin
               cp       = {code_acc[11:0], nibble_of(b)};
               code_acc = cp;
               if (digits_taken != 2'd3) begin
                  digits_taken = digits_taken + 2'd1;
               end else begin
                  digits_taken = 2'd0;
                  scan_mode    = SCAN_STRING;
                  // encode as UTF-8, one to three bytes; drop a zero code point
                  if (cp == 16'h0000) begin
                  end else if (cp < 16'h0080) begin
                     emit(cp[7:0], ST_DATA);
                  end else if (cp < 16'h0800) begin
                     emit({3'b110, cp[10:6]}, ST_DATA);
                     emit({2'b10, cp[5:0]}, ST_DATA);
                  end else begin
                     emit({4'b1110, cp[15:12]}, ST_DATA);
                     emit({2'b10, cp[11:6]}, ST_DATA);
                     emit({2'b10, cp[5:0]}, ST_DATA);
                  end
               end
            end
         end
      endcase
      if (byte_group.size() != 0) begin
         tail = byte_group.pop_back();
         tail.run_last = 1'b1;
         byte_group.push_back(tail);
      end
   endtask

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      errors++;
      $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, want_v);
   endtask

   always @(posedge clock) begin : scoreboard
      stim_row_type row;
      decoded_type  got;
      decoded_type  want;
      decoded_type  typed_result;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row = pending_rows.pop_front();
            decode_text(req_text_byte);
            items_accepted++;
            if (row.typed) begin
               typed_result = '{row.exp_byte, row.exp_status, 1'b1};
               expected_q.push_back(typed_result);
            end else begin
               foreach (byte_group[i]) expected_q.push_back(byte_group[i]);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_status, rsp_run_last};
            results_seen++;
            status_count[got.status]++;
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected", int'(got), 0);
            end else begin
               want = expected_q.pop_front();
               if (got.out_byte != want.out_byte)
                  report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
               if (got.status != want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.run_last != want.run_last)
                  report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
            end
         end
      end
   end

   // Output stall: random, quiet on request, or one long counted hold-off.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
         end else begin
            rsp_stall <= !rsp_quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   task automatic offer_row(input stim_row_type row);
      if (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= row.text;
      pending_rows.push_back(row);
      items_offered++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic offer_text(input logic [7:0] b);
      stim_row_type row;
      row = '{b, 1'b0, 8'h00, ST_DATA};
      offer_row(row);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic send_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(255, 1)); while (b == CH_QUOTE || b == CH_BSL);
      offer_text(b);
   endtask

   task automatic send_simple_escape();
      logic [7:0] b;
      offer_text(CH_BSL);
      if ($urandom_range(1) == 0) begin
         b = escape_letters[$urandom_range(4)];
      end else begin
         do b = 8'($urandom_range(255, 1)); while (b == CH_U);
      end
      offer_text(b);
   endtask

   task automatic send_digits(input logic [15:0] cp, input int count);
      logic [7:0] c;
      for (int i = 3; i > 3 - count; i--) begin
         c = hex_char(cp[4*i +: 4], 1'($urandom_range(1)));
         // now and then replace a digit by a byte that is not hex
         if ($urandom_range(19) == 0) begin
            case ($urandom_range(2))
               0:       c = 8'h67 + 8'($urandom_range(19));
               1:       c = CH_QUOTE;
               default: c = CH_BSL;
            endcase
         end
         offer_text(c);
      end
   endtask

   task automatic send_code_point(input logic [15:0] cp);
      offer_text(CH_BSL);
      offer_text(CH_U);
      send_digits(cp, 4);
   endtask

   function automatic logic [15:0] random_code_point();
      logic [15:0] edges [6] = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
      if ($urandom_range(7) == 0) return edges[$urandom_range(5)];
      case ($urandom_range(9))
         0:       return 16'h0000;
         1, 2, 3: return 16'($urandom_range(16'h007F, 16'h0001));
         4, 5, 6: return 16'($urandom_range(16'h07FF, 16'h0080));
         default: return 16'($urandom_range(16'hFFFF, 16'h0800));
      endcase
   endfunction

   task automatic send_string(input int tokens, input logic broken);
      int pick;
      offer_text(CH_QUOTE);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(9);
         if (pick < 5) send_plain();
         else if (pick < 7) send_simple_escape();
         else send_code_point(random_code_point());
      end
      if (!broken) begin
         offer_text(CH_QUOTE);
      end else begin
         case ($urandom_range(2))
            0: ;
            1: offer_text(CH_BSL);
            default: begin
               offer_text(CH_BSL);
               offer_text(CH_U);
               send_digits(random_code_point(), $urandom_range(3));
            end
         endcase
         offer_text(CH_NUL);
      end
   endtask

   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(3, 1)) begin
         do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
         offer_text(b);
      end
   endtask

   initial begin : stimulus
      int random_start;
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) offer_row(directed_rows[i]);
      wait_drained();

      // hold the output while a burst of three-byte escapes streams in
      hold_request = 1'b1;
      sender_quiet = 1'b1;
      offer_text(CH_QUOTE);
      repeat (10) send_code_point(16'($urandom_range(16'hFFFF, 16'h0800)));
      offer_text(CH_QUOTE);
      sender_quiet = 1'b0;
      wait_drained();

      random_start = items_offered;
      sender_quiet = 1'b1;
      rsp_quiet    = 1'b1;
      while (items_offered - random_start < RANDOM_ITEMS) begin
         if (items_offered - random_start >= QUIET_ITEMS) begin
            sender_quiet = 1'b0;
            rsp_quiet    = 1'b0;
         end
         pick = $urandom_range(9);
         if (pick == 0) send_noise();
         else if (pick == 1) send_string($urandom_range(6), 1'b1);
         else send_string($urandom_range(8), 1'b0);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("results never delivered", 0, expected_q.size());

      $display("Decoded %0d text bytes into %0d results, incl. a %0d-cycle output hold-off.",
               items_accepted, results_seen, HOLD_CYCLES);
      $display("Status mix: %0d data, %0d closed, %0d unterminated, %0d missing quote.",
               status_count[ST_DATA], status_count[ST_CLOSED],
               status_count[ST_UNTERM], status_count[ST_NOOPEN]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #200000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== json_string_unescape.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
tb/testbench.sv
